[sv/rbpg_pkg.sv]
// ----------------------------------------------------------------------------
// rbpg_pkg
// Shared types and codes for the rectangle and blit pixel generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rbpg_pkg;

  localparam int POS_W    = 11;   // signed corner / origin
  localparam int CORNER_W = 10;   // unsigned far corner
  localparam int BW_W     = 10;   // blit width
  localparam int BH_W     = 9;    // blit height
  localparam int PIX_W    = 8;
  localparam int MODE_W   = 3;
  localparam int STAT_W   = 2;
  localparam int ADDR_W   = 18;
  localparam int EXT_W    = 12;   // signed working width for positions

  localparam int PIXEL_BYTES = 1;

  localparam logic [MODE_W-1:0] MODE_FILL    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_OUTLINE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BLIT    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SOURCE  = 3'd4;

  localparam logic [STAT_W-1:0] ST_WRITE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_CLIPPED = 2'd1;
  localparam logic [STAT_W-1:0] ST_REJECT  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [POS_W-1:0]    pos_x1;
    logic [POS_W-1:0]    pos_y1;
    logic [CORNER_W-1:0] pos_x2;
    logic [CORNER_W-1:0] pos_y2;
    logic [BW_W-1:0]     blit_width;
    logic [BH_W-1:0]     blit_height;
    logic [PIX_W-1:0]    colour_index;
    logic [PIX_W-1:0]    source_pixel;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] pixel_address;
    logic [PIX_W-1:0]  pixel_value;
    logic [STAT_W-1:0] status;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

[sv/rbpg_addr_calc.sv]
// ----------------------------------------------------------------------------
// rbpg_addr_calc
// Framebuffer byte offset from an on-screen column and row.
// ----------------------------------------------------------------------------
`default_nettype none

module rbpg_addr_calc #(
  parameter int SCREEN_COLS = 640,
  parameter int SCREEN_ROWS = 400
) (
  input  wire logic [$clog2(SCREEN_COLS)-1:0] col,
  input  wire logic [$clog2(SCREEN_ROWS)-1:0] row,
  output logic [rbpg_pkg::ADDR_W-1:0]         addr
);
  import rbpg_pkg::*;

  localparam int ROW_W = $clog2(SCREEN_ROWS);
  localparam int RAW_W = ROW_W + $clog2(SCREEN_COLS + 1) + 2;
  localparam int SUM_W = (RAW_W > ADDR_W) ? RAW_W : ADDR_W;

  logic [SUM_W-1:0] sum;

  // multiply by a constant row pitch, then wrap to the address width
  assign sum  = (SUM_W'(row) * SUM_W'(SCREEN_COLS) + SUM_W'(col)) * SUM_W'(PIXEL_BYTES);
  assign addr = sum[ADDR_W-1:0];

endmodule

`default_nettype wire

[sv/rbpg_engine.sv]
// ----------------------------------------------------------------------------
// rbpg_engine
// Command state and per-item pixel generation for fill, outline and blit.
// ----------------------------------------------------------------------------
`default_nettype none

module rbpg_engine #(
  parameter int SCREEN_COLS = 640,
  parameter int SCREEN_ROWS = 400
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire rbpg_pkg::item_t  item,
  output logic                  res_valid,
  output rbpg_pkg::result_t     res
);
  import rbpg_pkg::*;

  localparam int COL_W = $clog2(SCREEN_COLS);
  localparam int ROW_W = $clog2(SCREEN_ROWS);

  localparam logic [1:0] CMD_IDLE    = 2'd0;
  localparam logic [1:0] CMD_FILL    = 2'd1;
  localparam logic [1:0] CMD_OUTLINE = 2'd2;
  localparam logic [1:0] CMD_BLIT    = 2'd3;

  localparam logic signed [EXT_W-1:0] COLS_S     = EXT_W'(SCREEN_COLS);
  localparam logic signed [EXT_W-1:0] ROWS_S     = EXT_W'(SCREEN_ROWS);
  localparam logic signed [EXT_W-1:0] COLS_LAST  = EXT_W'(SCREEN_COLS - 1);
  localparam logic signed [EXT_W-1:0] ROWS_LAST  = EXT_W'(SCREEN_ROWS - 1);

  logic [1:0]       active_command;
  logic [COL_W-1:0] left_col, right_col, cursor_col;
  logic [ROW_W-1:0] top_row, bottom_row, cursor_row;
  logic [PIX_W-1:0] held_colour;
  logic [POS_W-1:0] origin_col, origin_row;
  logic [BW_W-1:0]  blit_w, source_count_col;
  logic [BH_W-1:0]  blit_h, source_count_row;

  // rectangle start
  logic signed [EXT_W-1:0] x1s, y1s, x2s, y2s, lo_x, hi_x, lo_y, hi_y, clip_x, clip_y;
  logic                    rect_reject;

  assign x1s = EXT_W'($signed(item.pos_x1));
  assign y1s = EXT_W'($signed(item.pos_y1));
  assign x2s = $signed({2'b00, item.pos_x2});
  assign y2s = $signed({2'b00, item.pos_y2});

  always_comb begin
    if (x1s > x2s) begin
      lo_x = x2s;
      hi_x = x1s;
    end else begin
      lo_x = x1s;
      hi_x = x2s;
    end
    if (y1s > y2s) begin
      lo_y = y2s;
      hi_y = y1s;
    end else begin
      lo_y = y1s;
      hi_y = y2s;
    end
    clip_x = (hi_x > COLS_LAST) ? COLS_LAST : hi_x;
    clip_y = (hi_y > ROWS_LAST) ? ROWS_LAST : hi_y;
  end

  assign rect_reject = (lo_x < 0) || (lo_x >= COLS_S) || (lo_y < 0) || (lo_y >= ROWS_S);

  // blit start
  logic blit_reject;
  assign blit_reject = (item.blit_width == '0) || (item.blit_height == '0);

  // tick
  logic is_rect, tick_last, row_edge;
  assign is_rect   = (active_command == CMD_FILL) || (active_command == CMD_OUTLINE);
  assign tick_last = (cursor_col == right_col) && (cursor_row == bottom_row);
  assign row_edge  = (active_command == CMD_FILL) || (cursor_row == top_row) ||
                     (cursor_row == bottom_row);

  // source pixel
  logic signed [EXT_W-1:0] bcol, brow;
  logic [BW_W:0]           col_inc;
  logic [BH_W:0]           row_inc;
  logic                    src_last, src_on;

  assign bcol     = EXT_W'($signed(origin_col)) + $signed({2'b00, source_count_col});
  assign brow     = EXT_W'($signed(origin_row)) + $signed({3'b000, source_count_row});
  assign col_inc  = {1'b0, source_count_col} + 1'b1;
  assign row_inc  = {1'b0, source_count_row} + 1'b1;
  assign src_last = (col_inc == {1'b0, blit_w}) && (row_inc == {1'b0, blit_h});
  assign src_on   = (bcol >= 0) && (bcol < COLS_S) && (brow >= 0) && (brow < ROWS_S);

  // address of the pixel being written
  logic [COL_W-1:0]  addr_col;
  logic [ROW_W-1:0]  addr_row;
  logic [ADDR_W-1:0] addr;

  assign addr_col = (item.mode == MODE_TICK) ? cursor_col : bcol[COL_W-1:0];
  assign addr_row = (item.mode == MODE_TICK) ? cursor_row : brow[ROW_W-1:0];

  rbpg_addr_calc #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_addr (
    .col  (addr_col),
    .row  (addr_row),
    .addr (addr)
  );

  always_comb begin
    res_valid = 1'b0;
    res       = '{pixel_address: '0, pixel_value: '0, status: ST_REJECT, last: 1'b1};
    case (item.mode)
      MODE_FILL, MODE_OUTLINE: begin
        res_valid = rect_reject;
      end
      MODE_BLIT: begin
        res_valid = blit_reject;
      end
      MODE_TICK: begin
        res_valid = is_rect;
        res = '{pixel_address: addr, pixel_value: held_colour, status: ST_WRITE,
                last: tick_last};
      end
      MODE_SOURCE: begin
        res_valid = (active_command == CMD_BLIT) && (src_on || src_last);
        if (src_on) begin
          res = '{pixel_address: addr, pixel_value: item.source_pixel, status: ST_WRITE,
                  last: src_last};
        end else begin
          res = '{pixel_address: '0, pixel_value: '0, status: ST_CLIPPED, last: 1'b1};
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_command <= CMD_IDLE;
    end else if (advance) begin
      case (item.mode)
        MODE_FILL, MODE_OUTLINE: begin
          if (rect_reject) begin
            active_command <= CMD_IDLE;
          end else begin
            left_col       <= lo_x[COL_W-1:0];
            right_col      <= clip_x[COL_W-1:0];
            top_row        <= lo_y[ROW_W-1:0];
            bottom_row     <= clip_y[ROW_W-1:0];
            cursor_col     <= lo_x[COL_W-1:0];
            cursor_row     <= lo_y[ROW_W-1:0];
            held_colour    <= item.colour_index;
            active_command <= (item.mode == MODE_FILL) ? CMD_FILL : CMD_OUTLINE;
          end
        end
        MODE_BLIT: begin
          if (blit_reject) begin
            active_command <= CMD_IDLE;
          end else begin
            origin_col       <= item.pos_x1;
            origin_row       <= item.pos_y1;
            blit_w           <= item.blit_width;
            blit_h           <= item.blit_height;
            source_count_col <= '0;
            source_count_row <= '0;
            active_command   <= CMD_BLIT;
          end
        end
        MODE_TICK: begin
          if (is_rect) begin
            if (tick_last) begin
              active_command <= CMD_IDLE;
            end else if (cursor_col < right_col && row_edge) begin
              cursor_col <= cursor_col + 1'b1;
            end else if (active_command == CMD_OUTLINE && cursor_col == left_col &&
                         cursor_col < right_col) begin
              // jump across the inside of an outline row
              cursor_col <= right_col;
            end else begin
              cursor_row <= cursor_row + 1'b1;
              cursor_col <= left_col;
            end
          end
        end
        MODE_SOURCE: begin
          if (active_command == CMD_BLIT) begin
            if (col_inc >= {1'b0, blit_w}) begin
              source_count_col <= '0;
              source_count_row <= source_count_row + 1'b1;
            end else begin
              source_count_col <= col_inc[BW_W-1:0];
            end
            if (src_last) begin
              active_command <= CMD_IDLE;
            end
          end
        end
        default: begin
          active_command <= active_command;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/rect_and_blit_pixel_generator_core.sv]
// ----------------------------------------------------------------------------
// rect_and_blit_pixel_generator_core
// Fill, outline and clipped blit pixel writes for an 8-bit framebuffer.
// ----------------------------------------------------------------------------
// Every input transfer is one command or step: a fill, outline or blit start,
// a tick that yields the next rectangle pixel, or a source pixel of a blit.
// The block takes one transfer per cycle while the output does not stall it
// and gives at most one result per transfer: an input register feeds the command
// state and address logic (one constant multiply by SCREEN_COLS and an add),
// which loads an output register. Starts that are accepted give no result;
// rejected starts and clipped final blit pixels give a result with no write.
// The final result of a command run to its end has tlast set. Backpressure on
// the output stalls input only when an item that gives a result is waiting.
`default_nettype none

module rect_and_blit_pixel_generator_core #(
  parameter int SCREEN_COLS = 640,
  parameter int SCREEN_ROWS = 400
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // pos_x1[10:0], pos_y1[21:11], pos_x2[31:22], pos_y2[41:32], blit_width[51:42],
  // blit_height[60:52], colour_index[68:61], source_pixel[76:69], zero fill
  input  wire logic [79:0] s_axis_tdata,
  // mode[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // pixel_address[17:0], pixel_value[25:18], zero fill
  output logic [31:0]      m_axis_tdata,
  // status[1:0]
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);
  import rbpg_pkg::*;

  logic    in_valid;
  item_t   in_item;
  item_t   item_next;
  logic    advance;
  logic    res_valid;
  result_t res;
  logic    out_valid;
  result_t out_res;

  assign item_next = '{mode:         s_axis_tuser,
                       pos_x1:       s_axis_tdata[10:0],
                       pos_y1:       s_axis_tdata[21:11],
                       pos_x2:       s_axis_tdata[31:22],
                       pos_y2:       s_axis_tdata[41:32],
                       blit_width:   s_axis_tdata[51:42],
                       blit_height:  s_axis_tdata[60:52],
                       colour_index: s_axis_tdata[68:61],
                       source_pixel: s_axis_tdata[76:69]};

  // an item that gives no result never waits on the output side
  assign advance       = in_valid && (!res_valid || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= item_next;
    end
  end

  rbpg_engine #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (in_item),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_res.pixel_value, out_res.pixel_address};
  assign m_axis_tuser  = out_res.status;
  assign m_axis_tlast  = out_res.last;

endmodule

`default_nettype wire

[tb/rect_and_blit_pixel_generator_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_and_blit_pixel_generator_core_test
// Self-checking bench for the fill, outline and clipped blit pixel generator.
// Directed cases cover screen corners, degenerate outlines, rejected starts,
// clipped blit ends and aborts. Random rectangle and blit commands with
// random stray input follow, first with bursty gaps on the input stream and
// bursty backpressure on the output stream, then with neither. Every output
// transfer is checked against a local pixel predictor in order.
// ----------------------------------------------------------------------------
module rect_and_blit_pixel_generator_core_test;
  import rbpg_pkg::*;

  localparam int SCREEN_COLS = 640;
  localparam int SCREEN_ROWS = 400;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  typedef enum logic [1:0] {CMD_IDLE, CMD_FILL, CMD_OUTLINE, CMD_BLIT} cmd_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  rect_and_blit_pixel_generator_core #(
    .SCREEN_COLS(SCREEN_COLS),
    .SCREEN_ROWS(SCREEN_ROWS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  // predictor state
  cmd_t       cmd;
  int         left_c, right_c, top_r, bottom_r;
  int         cur_c, cur_r, src_c, src_r;
  logic [7:0] colour;

  result_t expected_pixels[$];

  bit src_idle;
  bit sink_stalls;
  int items_taken;
  int errors;
  int n_writes, n_clipped, n_rejects;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("rect_and_blit_pixel_generator_core_test: errors");
    $finish;
  end

  // works out the result an accepted item causes, if any
  function automatic bit predict_pixel(input item_t it, output result_t r);
    int x1, y1, x2, y2, t, col, row;
    bit fin, on;
    r = '0;
    case (it.mode)
      MODE_FILL, MODE_OUTLINE: begin
        x1 = $signed(it.pos_x1);
        y1 = $signed(it.pos_y1);
        x2 = it.pos_x2;
        y2 = it.pos_y2;
        if (y1 > y2) begin
          t = y1; y1 = y2; y2 = t;
        end
        if (x1 > x2) begin
          t = x1; x1 = x2; x2 = t;
        end
        if (x2 > SCREEN_COLS - 1) x2 = SCREEN_COLS - 1;
        if (y2 > SCREEN_ROWS - 1) y2 = SCREEN_ROWS - 1;
        if (x1 < 0 || y1 < 0 || x1 >= SCREEN_COLS || y1 >= SCREEN_ROWS) begin
          cmd = CMD_IDLE;
          r.status = ST_REJECT;
          r.last = 1'b1;
          return 1'b1;
        end
        left_c = x1; right_c = x2; top_r = y1; bottom_r = y2;
        cur_c = x1; cur_r = y1;
        colour = it.colour_index;
        cmd = (it.mode == MODE_FILL) ? CMD_FILL : CMD_OUTLINE;
        return 1'b0;
      end
      MODE_BLIT: begin
        if (it.blit_width == 0 || it.blit_height == 0) begin
          cmd = CMD_IDLE;
          r.status = ST_REJECT;
          r.last = 1'b1;
          return 1'b1;
        end
        cur_c = $signed(it.pos_x1);
        cur_r = $signed(it.pos_y1);
        right_c = it.blit_width;
        bottom_r = it.blit_height;
        src_c = 0;
        src_r = 0;
        cmd = CMD_BLIT;
        return 1'b0;
      end
      MODE_TICK: begin
        if (cmd != CMD_FILL && cmd != CMD_OUTLINE) return 1'b0;
        fin = (cur_c == right_c && cur_r == bottom_r);
        r.pixel_address = ADDR_W'((cur_r * SCREEN_COLS + cur_c) * PIXEL_BYTES);
        r.pixel_value = colour;
        r.status = ST_WRITE;
        r.last = fin;
        if (fin) begin
          cmd = CMD_IDLE;
        end else if (cur_c < right_c &&
                     (cmd == CMD_FILL || cur_r == top_r || cur_r == bottom_r)) begin
          cur_c++;
        end else if (cmd == CMD_OUTLINE && cur_c == left_c && cur_c < right_c) begin
          // skip the inside of an outline row
          cur_c = right_c;
        end else begin
          cur_r++;
          cur_c = left_c;
        end
        return 1'b1;
      end
      MODE_SOURCE: begin
        if (cmd != CMD_BLIT) return 1'b0;
        col = cur_c + src_c;
        row = cur_r + src_r;
        fin = (src_c + 1 == right_c && src_r + 1 == bottom_r);
        src_c++;
        if (src_c >= right_c) begin
          src_c = 0;
          src_r++;
        end
        if (fin) cmd = CMD_IDLE;
        on = (col >= 0 && col < SCREEN_COLS && row >= 0 && row < SCREEN_ROWS);
        if (on) begin
          r.pixel_address = ADDR_W'((row * SCREEN_COLS + col) * PIXEL_BYTES);
          r.pixel_value = it.source_pixel;
          r.status = ST_WRITE;
          r.last = fin;
          return 1'b1;
        end
        if (fin) begin
          r.status = ST_CLIPPED;
          r.last = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic item_t rand_item(input logic [MODE_W-1:0] mode);
    logic [95:0] bits;
    item_t it;
    bits = {$urandom, $urandom, $urandom};
    it = bits[79:0];
    it.mode = mode;
    return it;
  endfunction

  task automatic send_item(input item_t it);
    result_t r;
    bit effective;
    if (src_idle && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, it.source_pixel, it.colour_index, it.blit_height,
                     it.blit_width, it.pos_y2, it.pos_x2, it.pos_y1, it.pos_x1};
    s_axis_tuser <= it.mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    effective = !(it.mode > MODE_SOURCE ||
                  (it.mode == MODE_TICK && cmd != CMD_FILL && cmd != CMD_OUTLINE) ||
                  (it.mode == MODE_SOURCE && cmd != CMD_BLIT));
    if (effective) items_taken++;
    if (predict_pixel(it, r)) expected_pixels.push_back(r);
  endtask

  task automatic send_step(input logic [MODE_W-1:0] mode);
    send_item(rand_item(mode));
  endtask

  task automatic send_rect(input logic [MODE_W-1:0] mode, input int x1, input int y1,
                           input int x2, input int y2);
    item_t it;
    it = rand_item(mode);
    it.pos_x1 = POS_W'(x1);
    it.pos_y1 = POS_W'(y1);
    it.pos_x2 = CORNER_W'(x2);
    it.pos_y2 = CORNER_W'(y2);
    send_item(it);
  endtask

  task automatic send_blit(input int x, input int y, input int w, input int h);
    item_t it;
    it = rand_item(MODE_BLIT);
    it.pos_x1 = POS_W'(x);
    it.pos_y1 = POS_W'(y);
    it.blit_width = BW_W'(w);
    it.blit_height = BH_W'(h);
    send_item(it);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endtask

  // output side: random backpressure bursts
  initial begin
    int hold;
    m_axis_tready <= 1'b0;
    hold = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        if (hold == 0) m_axis_tready <= 1'b1;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        hold = $urandom_range(1, 9);
      end
    end
  end

  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.pixel_address = m_axis_tdata[17:0];
      got.pixel_value = m_axis_tdata[25:18];
      got.status = m_axis_tuser;
      got.last = m_axis_tlast;
      case (got.status)
        ST_WRITE:   n_writes++;
        ST_CLIPPED: n_clipped++;
        default:    n_rejects++;
      endcase
      if (expected_pixels.size() == 0) begin
        note_error($sformatf("unexpected transfer addr %0d value %02h status %0d last %0d",
                             got.pixel_address, got.pixel_value, got.status, got.last));
      end else begin
        want = expected_pixels.pop_front();
        if (got.pixel_address !== want.pixel_address || got.pixel_value !== want.pixel_value ||
            got.status !== want.status || got.last !== want.last)
          note_error($sformatf({"expected addr %0d value %02h status %0d last %0d, ",
                                "got addr %0d value %02h status %0d last %0d"},
                               want.pixel_address, want.pixel_value, want.status, want.last,
                               got.pixel_address, got.pixel_value, got.status, got.last));
      end
    end
  end

  task automatic test_stray_input();
    send_step(MODE_TICK);
    send_step(MODE_SOURCE);
    send_step(MODE_UNUSED_HI);
  endtask

  task automatic test_fill_edges();
    send_rect(MODE_FILL, 0, 0, 0, 0);
    send_step(MODE_TICK);
    // corners given backwards, far corner clipped to the bottom-right pixel
    send_rect(MODE_FILL, 1023, 1023, 638, 398);
    repeat (4) send_step(MODE_TICK);
  endtask

  task automatic test_outline_degenerate();
    send_rect(MODE_OUTLINE, 12, 5, 10, 5);
    repeat (3) send_step(MODE_TICK);
    send_rect(MODE_OUTLINE, 7, 3, 7, 2);
    repeat (2) send_step(MODE_TICK);
  endtask

  task automatic test_rejects();
    send_rect(MODE_FILL, -1024, 0, 5, 5);
    send_rect(MODE_OUTLINE, 0, 1023, 3, 600);
    send_blit(0, 0, 0, 5);
  endtask

  task automatic test_blit_clipping();
    send_blit(639, 399, 2, 1);
    repeat (2) send_step(MODE_SOURCE);
    send_blit(-1, 0, 2, 1);
    repeat (2) send_step(MODE_SOURCE);
  endtask

  task automatic test_abort();
    send_blit(-1024, -1024, 1023, 511);
    send_step(MODE_SOURCE);
    send_rect(MODE_FILL, 0, 0, 1023, 1023);
    send_step(MODE_TICK);
  endtask

  // cut < 0 runs the command to its end, else it is abandoned after cut steps
  task automatic run_rect(input logic [MODE_W-1:0] mode, input int cut);
    int x1, y1, x2, y2, steps;
    if ($urandom_range(0, 3) == 0) begin
      x1 = $urandom_range(630, 639);
      x2 = $urandom_range(x1, 1023);
      y1 = $urandom_range(392, 399);
      y2 = $urandom_range(y1, 1023);
    end else begin
      x1 = $urandom_range(0, 632);
      x2 = x1 + $urandom_range(0, 7);
      y1 = $urandom_range(0, 394);
      y2 = y1 + $urandom_range(0, 5);
    end
    if ($urandom_range(0, 1)) begin
      steps = x1; x1 = x2; x2 = steps;
    end
    if ($urandom_range(0, 1)) begin
      steps = y1; y1 = y2; y2 = steps;
    end
    send_rect(mode, x1, y1, x2, y2);
    steps = 0;
    while ((cmd == CMD_FILL || cmd == CMD_OUTLINE) && (cut < 0 || steps < cut)) begin
      send_step(MODE_TICK);
      steps++;
    end
  endtask

  function automatic int pick_origin(input int size, input int span);
    case ($urandom_range(0, 3))
      0:       return int'($urandom_range(0, size + 2)) - size - 1;
      1:       return span - 6 + int'($urandom_range(0, 7));
      2:       return $urandom_range(0, span - 10);
      default: return int'($urandom_range(0, 2047)) - 1024;
    endcase
  endfunction

  task automatic run_blit(input int cut);
    int w, h, steps;
    w = $urandom_range(1, 6);
    h = $urandom_range(1, 4);
    send_blit(pick_origin(w, SCREEN_COLS), pick_origin(h, SCREEN_ROWS), w, h);
    steps = 0;
    while (cmd == CMD_BLIT && (cut < 0 || steps < cut)) begin
      send_step(MODE_SOURCE);
      steps++;
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 6))
      0: send_step(MODE_TICK);
      1: send_step(MODE_SOURCE);
      2: send_step(MODE_UNUSED_LO + MODE_W'($urandom_range(0, 2)));
      3: send_rect($urandom_range(0, 1) ? MODE_FILL : MODE_OUTLINE,
                   -int'($urandom_range(1, 1024)), $urandom_range(0, 399),
                   $urandom_range(0, 1023), $urandom_range(0, 1023));
      4: send_rect(MODE_FILL, $urandom_range(640, 1023), $urandom_range(0, 399),
                   $urandom_range(640, 1023), $urandom_range(0, 1023));
      5: send_rect(MODE_OUTLINE, $urandom_range(0, 639), -int'($urandom_range(1, 1024)),
                   $urandom_range(0, 1023), $urandom_range(400, 1023));
      default: send_blit(int'($urandom_range(0, 2047)) - 1024,
                         int'($urandom_range(0, 2047)) - 1024,
                         $urandom_range(0, 1) ? 0 : $urandom_range(0, 1023),
                         $urandom_range(0, 1) ? 0 : $urandom_range(0, 511));
    endcase
  endtask

  task automatic test_random_traffic(input int n_items);
    int stop_at;
    stop_at = items_taken + n_items;
    while (items_taken < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2: run_rect(MODE_FILL, -1);
        3, 4:    run_rect(MODE_OUTLINE, -1);
        5, 6, 7: run_blit(-1);
        8:       send_noise();
        default: begin
          // abandoned command: the next start aborts it
          case ($urandom_range(0, 2))
            0:       run_rect(MODE_FILL, $urandom_range(0, 3));
            1:       run_rect(MODE_OUTLINE, $urandom_range(0, 3));
            default: run_blit($urandom_range(0, 3));
          endcase
        end
      endcase
    end
  endtask

  task automatic test_unpaced_traffic(input int n_items);
    src_idle = 1'b0;
    sink_stalls = 1'b0;
    test_random_traffic(n_items);
  endtask

  initial begin
    cmd = CMD_IDLE;
    left_c = 0; right_c = 0; top_r = 0; bottom_r = 0;
    cur_c = 0; cur_r = 0; src_c = 0; src_r = 0;
    colour = '0;
    items_taken = 0;
    errors = 0;
    n_writes = 0; n_clipped = 0; n_rejects = 0;
    src_idle = 1'b1;
    sink_stalls = 1'b1;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_stray_input();
    test_fill_edges();
    test_outline_degenerate();
    test_rejects();
    test_blit_clipping();
    test_abort();
    wait_for_results();
    test_random_traffic(600);
    wait_for_results();
    test_unpaced_traffic(250);
    wait_for_results();
    repeat (8) @(posedge clk);

    $display("run covered %0d effective items: %0d pixel writes, %0d clipped blit ends,",
             items_taken, n_writes, n_clipped);
    $display("%0d rejected starts, with stalls on both streams; %0d mismatches",
             n_rejects, errors);
    if (errors == 0) begin
      $display("rect_and_blit_pixel_generator_core_test: clean");
    end else begin
      $display("rect_and_blit_pixel_generator_core_test: errors");
    end
    $finish;
  end

endmodule

[files.f]
sv/rbpg_pkg.sv
sv/rbpg_addr_calc.sv
sv/rbpg_engine.sv
sv/rect_and_blit_pixel_generator_core.sv
tb/rect_and_blit_pixel_generator_core_test.sv
